// ===== rtl/core/ntr_pkg.sv =====
// package: scan state codes, result codes and character classes for the numeric token recognizer
`default_nettype none
package ntr_pkg;

    localparam int unsigned CharWidth   = 8;
    localparam int unsigned ActionWidth = 2;
    localparam int unsigned StatusWidth = 2;
    localparam int unsigned LenWidth    = 8;

    // packed result width, rounded up to whole bytes
    localparam int unsigned ResultBits = CharWidth + ActionWidth + StatusWidth + LenWidth;
    localparam int unsigned MTdataWidth = ((ResultBits + 7) / 8) * 8;

    localparam logic [LenWidth-1:0] MaxTokenLenReset = 8'd120;

    typedef enum logic [4:0] {
        ST_START   = 5'd0,
        ST_WS      = 5'd1,
        ST_MANT    = 5'd2,
        ST_FRAC0   = 5'd3,
        ST_FRAC    = 5'd4,
        ST_EXP0    = 5'd5,
        ST_EXPS    = 5'd6,
        ST_EXPD    = 5'd7,
        ST_NAN1    = 5'd8,
        ST_NAN2    = 5'd9,
        ST_NANDONE = 5'd10,
        ST_PAY     = 5'd11,
        ST_DONE    = 5'd12,
        ST_INF1    = 5'd13,
        ST_INF2    = 5'd14,
        ST_INF3    = 5'd15,
        ST_INF4    = 5'd16,
        ST_INF5    = 5'd17,
        ST_INF6    = 5'd18,
        ST_INF7    = 5'd19,
        ST_SIGNED  = 5'd20
    } scan_state_t;

    typedef enum logic [ActionWidth-1:0] {
        ACT_SKIP    = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_END_CH  = 2'd2,
        ACT_END_EOI = 2'd3
    } action_t;

    typedef enum logic [StatusWidth-1:0] {
        STS_NONE   = 2'd0,
        STS_NUMBER = 2'd1,
        STS_EOF    = 2'd2
    } status_t;

    typedef struct packed {
        logic        match;
        scan_state_t next;
    } step_t;

    function automatic logic is_space(input logic [CharWidth-1:0] c);
        return c inside {8'h20, 8'h0c, 8'h0a, 8'h0d, 8'h09, 8'h0b};
    endfunction

    function automatic logic is_digit(input logic [CharWidth-1:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alnum(input logic [CharWidth-1:0] c);
        return c inside {["0":"9"], ["A":"Z"], ["a":"z"]};
    endfunction

    function automatic logic [CharWidth-1:0] to_lower(input logic [CharWidth-1:0] c);
        return (c inside {["A":"Z"]}) ? (c | 8'h20) : c;
    endfunction

    // one step of the token grammar: does c extend the token, and where to
    function automatic step_t classify(input scan_state_t st, input logic [CharWidth-1:0] c);
        step_t           r;
        scan_state_t     eff;
        logic [CharWidth-1:0] lc;
        r.match = 1'b0;
        r.next  = ST_DONE;
        eff     = st;
        lc      = to_lower(c);
        // sign and word starts are optional prefixes that fall through
        if ((eff == ST_START) || (eff == ST_WS)) begin
            if ((c == "+") || (c == "-")) begin
                r.match = 1'b1;
                r.next  = ST_SIGNED;
                return r;
            end
            eff = ST_SIGNED;
        end
        if (eff == ST_SIGNED) begin
            if (lc == "n") begin
                r.match = 1'b1;
                r.next  = ST_NAN1;
                return r;
            end
            if (lc == "i") begin
                r.match = 1'b1;
                r.next  = ST_INF1;
                return r;
            end
            eff = ST_MANT;
        end
        case (eff)
            ST_MANT: begin
                if (is_digit(c)) begin
                    r.match = 1'b1; r.next = ST_MANT;
                end else if (c == ".") begin
                    r.match = 1'b1; r.next = ST_FRAC0;
                end else if (lc == "e") begin
                    r.match = 1'b1; r.next = ST_EXP0;
                end
            end
            ST_FRAC0: begin
                if (is_digit(c)) begin
                    r.match = 1'b1; r.next = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (is_digit(c)) begin
                    r.match = 1'b1; r.next = ST_FRAC;
                end else if (lc == "e") begin
                    r.match = 1'b1; r.next = ST_EXP0;
                end
            end
            ST_EXP0: begin
                if ((c == "+") || (c == "-")) begin
                    r.match = 1'b1; r.next = ST_EXPS;
                end else if (is_digit(c)) begin
                    r.match = 1'b1; r.next = ST_EXPD;
                end
            end
            ST_EXPS, ST_EXPD: begin
                if (is_digit(c)) begin
                    r.match = 1'b1; r.next = ST_EXPD;
                end
            end
            ST_NAN1: begin
                if (lc == "a") begin
                    r.match = 1'b1; r.next = ST_NAN2;
                end
            end
            ST_NAN2: begin
                if (lc == "n") begin
                    r.match = 1'b1; r.next = ST_NANDONE;
                end
            end
            ST_NANDONE: begin
                if (c == "(") begin
                    r.match = 1'b1; r.next = ST_PAY;
                end
            end
            ST_PAY: begin
                if (is_alnum(c) || (c == "_")) begin
                    r.match = 1'b1; r.next = ST_PAY;
                end else if (c == ")") begin
                    r.match = 1'b1; r.next = ST_DONE;
                end
            end
            // rest of "infinity" after the leading i
            ST_INF1: begin
                if (lc == "n") begin
                    r.match = 1'b1; r.next = ST_INF2;
                end
            end
            ST_INF2: begin
                if (lc == "f") begin
                    r.match = 1'b1; r.next = ST_INF3;
                end
            end
            ST_INF3: begin
                if (lc == "i") begin
                    r.match = 1'b1; r.next = ST_INF4;
                end
            end
            ST_INF4: begin
                if (lc == "n") begin
                    r.match = 1'b1; r.next = ST_INF5;
                end
            end
            ST_INF5: begin
                if (lc == "i") begin
                    r.match = 1'b1; r.next = ST_INF6;
                end
            end
            ST_INF6: begin
                if (lc == "t") begin
                    r.match = 1'b1; r.next = ST_INF7;
                end
            end
            ST_INF7: begin
                if (lc == "y") begin
                    r.match = 1'b1; r.next = ST_DONE;
                end
            end
            default: begin
                r.match = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/numeric_token_recognizer_unit.sv =====
// top level: numeric token recognizer, one character per item, one result per item
`default_nettype none
// Scans a character stream and recognizes the longest leading numeric token of each
// scan: leading whitespace, optional sign, then nan with an optional (payload), a
// case-insensitive prefix of infinity, or decimal digits with optional fraction and
// exponent. Each input item gives exactly one result item that marks the character as
// skipped whitespace, appended to the token, or the terminator (handed back, not
// consumed; the next item starts a fresh scan), or reports end of input. The grammar
// step is a single pass of logic from the accepted item and the scan state into the
// result register, so one item is taken per clock unless m_tready stalls; the result
// register is the only buffer, and s_tready drops only while a result waits on a
// stalled m_tready. The user must write max_token_len through cfg_we/cfg_wdata only
// while the stream is idle; the block does not enforce this. max_token_len resets to 120.
module numeric_token_recognizer_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write, max_token_len
    input  wire logic                                cfg_we,
    input  wire logic [ntr_pkg::LenWidth-1:0]        cfg_wdata,
    // input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ntr_pkg::CharWidth-1:0]       s_tdata,  // [7:0] ch
    input  wire logic                                s_tuser,  // [0] end_of_input
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ntr_pkg::MTdataWidth-1:0]          m_tdata   // [7:0] ch_out, [9:8] action,
                                                               // [11:10] status,
                                                               // [19:12] token_len, rest zero
);
    import ntr_pkg::*;

    // scan state and configuration
    scan_state_t           state_reg, state_next;
    logic [LenWidth-1:0]   count_reg, count_next;
    logic [LenWidth-1:0]   max_len_reg;

    // result register
    logic                  m_valid_reg;
    logic [CharWidth-1:0]  ch_out_next;
    action_t               action_next;
    status_t               status_next;
    logic [LenWidth-1:0]   len_next;
    logic [MTdataWidth-1:0] m_data_reg, m_data_next;

    logic                  accept;
    step_t                 step;
    logic                  has_token;

    // the result register frees as it is drained, so take a new item in the same cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign step      = classify(state_reg, s_tdata);
    assign has_token = (count_reg != '0);

    // grammar step: next scan state and the result for this character
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ch_out_next = s_tdata;
        action_next = ACT_END_CH;
        status_next = has_token ? STS_NUMBER : STS_NONE;
        len_next    = count_reg;
        if (s_tuser) begin
            // end of input closes the scan; nothing at all seen gives end of file
            ch_out_next = '0;
            action_next = ACT_END_EOI;
            if (state_reg == ST_START) begin
                status_next = STS_EOF;
            end
            state_next = ST_START;
            count_next = '0;
        end else if (((state_reg == ST_START) || (state_reg == ST_WS)) && is_space(s_tdata)) begin
            action_next = ACT_SKIP;
            status_next = STS_NONE;
            len_next    = '0;
            state_next  = ST_WS;
        end else if (step.match && (count_reg < max_len_reg)) begin
            // count cannot wrap: it stays below max_len_reg before the add
            count_next  = count_reg + 1'b1;
            state_next  = step.next;
            action_next = ACT_APPEND;
            status_next = STS_NONE;
            len_next    = count_reg + 1'b1;
        end else begin
            // terminator, or the length limit reached: hand the character back
            state_next = ST_START;
            count_next = '0;
        end
    end

    always_comb begin
        m_data_next = '0;
        m_data_next[ResultBits-1:0] = {len_next, status_next, action_next, ch_out_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_START;
            count_reg   <= '0;
            max_len_reg <= MaxTokenLenReset;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            if (accept) begin
                state_reg   <= state_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_numeric_token_recognizer_unit.sv =====
// testbench for numeric_token_recognizer_unit: scan predictor, random character streams, stalls
`timescale 1ns / 1ps

module tb_numeric_token_recognizer_unit;
    import ntr_pkg::*;

    // one input item: character plus end-of-input flag
    typedef struct packed {
        logic                 eoi;
        logic [CharWidth-1:0] ch;
    } char_item_t;

    // one predicted result item
    typedef struct packed {
        logic [CharWidth-1:0] ch_out;
        action_t              action;
        status_t              status;
        logic [LenWidth-1:0]  token_len;
    } scan_result_t;

    // remaining letters of the two words once the leading n or i has matched
    localparam logic [15:0] NanTail = "an";
    localparam logic [55:0] InfTail = "nfinity";

    // long receiver hold-off, started at these result counts
    localparam int unsigned HoldOffCycles = 80;
    localparam int unsigned HoldOffAtA    = 250;
    localparam int unsigned HoldOffAtB    = 700;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [LenWidth-1:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [CharWidth-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [MTdataWidth-1:0] m_tdata;

    // predictor copy of the scan state and the length limit
    logic [4:0]          scan_st   = ST_START;
    logic [LenWidth-1:0] tok_cnt   = '0;
    logic [LenWidth-1:0] tok_limit = MaxTokenLenReset;

    char_item_t   pending_chars [$];
    scan_result_t expected_results [$];
    char_item_t   drv_item;
    scan_result_t want;

    logic        idle_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned ready_hold = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned chars_queued = 0;
    int unsigned phase_limits [6];

    numeric_token_recognizer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic ws_char(input logic [7:0] c);
        return (c >= 8'h09 && c <= 8'h0d) || c == 8'h20;
    endfunction

    function automatic logic dec_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return dec_digit(c) || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // does c extend the token from state st; nxt is where the scan goes
    function automatic logic grammar_step(input logic [4:0] st, input logic [7:0] c,
                                          output logic [4:0] nxt);
        logic [4:0] eff;
        logic [7:0] lc;
        int         k;
        eff = st;
        lc  = lower_case(c);
        nxt = ST_DONE;
        // optional sign, then the first letter of nan or inf, then digits
        if (eff == ST_START || eff == ST_WS) begin
            if (c == "+" || c == "-") begin
                nxt = ST_SIGNED;
                return 1'b1;
            end
            eff = ST_SIGNED;
        end
        if (eff == ST_SIGNED) begin
            if (lc == "n") begin
                nxt = ST_NAN1;
                return 1'b1;
            end
            if (lc == "i") begin
                nxt = ST_INF1;
                return 1'b1;
            end
            eff = ST_MANT;
        end
        if (eff == ST_NAN1 || eff == ST_NAN2) begin
            k = int'(eff - ST_NAN1);
            if (lc != NanTail[15 - 8*k -: 8]) return 1'b0;
            nxt = (eff == ST_NAN2) ? ST_NANDONE : ST_NAN2;
            return 1'b1;
        end
        if (eff >= ST_INF1 && eff <= ST_INF7) begin
            k = int'(eff - ST_INF1);
            if (lc != InfTail[55 - 8*k -: 8]) return 1'b0;
            nxt = (eff == ST_INF7) ? ST_DONE : eff + 5'd1;
            return 1'b1;
        end
        case (eff)
            ST_MANT: begin
                if (dec_digit(c)) nxt = ST_MANT;
                else if (c == ".") nxt = ST_FRAC0;
                else if (lc == "e") nxt = ST_EXP0;
                else return 1'b0;
                return 1'b1;
            end
            ST_FRAC0: begin
                if (!dec_digit(c)) return 1'b0;
                nxt = ST_FRAC;
                return 1'b1;
            end
            ST_FRAC: begin
                if (dec_digit(c)) nxt = ST_FRAC;
                else if (lc == "e") nxt = ST_EXP0;
                else return 1'b0;
                return 1'b1;
            end
            ST_EXP0: begin
                if (c == "+" || c == "-") nxt = ST_EXPS;
                else if (dec_digit(c)) nxt = ST_EXPD;
                else return 1'b0;
                return 1'b1;
            end
            ST_EXPS, ST_EXPD: begin
                if (!dec_digit(c)) return 1'b0;
                nxt = ST_EXPD;
                return 1'b1;
            end
            ST_NANDONE: begin
                if (c != "(") return 1'b0;
                nxt = ST_PAY;
                return 1'b1;
            end
            ST_PAY: begin
                if (word_char(c)) nxt = ST_PAY;
                else if (c == ")") nxt = ST_DONE;
                else return 1'b0;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // result of one accepted item; advances the predictor state
    function automatic scan_result_t predict_scan(input char_item_t it);
        scan_result_t r;
        logic [4:0]   nxt;
        logic         hit;
        r.ch_out    = it.ch;
        r.action    = ACT_SKIP;
        r.status    = STS_NONE;
        r.token_len = '0;
        if (it.eoi) begin
            r.ch_out    = '0;
            r.action    = ACT_END_EOI;
            r.status    = (scan_st == ST_START) ? STS_EOF :
                          ((tok_cnt != 0) ? STS_NUMBER : STS_NONE);
            r.token_len = tok_cnt;
            scan_st     = ST_START;
            tok_cnt     = '0;
            return r;
        end
        if ((scan_st == ST_START || scan_st == ST_WS) && ws_char(it.ch)) begin
            scan_st = ST_WS;
            return r;
        end
        hit = grammar_step(scan_st, it.ch, nxt);
        if (hit && tok_cnt < tok_limit) begin
            tok_cnt     = tok_cnt + 8'd1;
            scan_st     = nxt;
            r.action    = ACT_APPEND;
            r.token_len = tok_cnt;
            return r;
        end
        // terminator handed back, next item starts a new scan
        r.action    = ACT_END_CH;
        r.status    = (tok_cnt != 0) ? STS_NUMBER : STS_NONE;
        r.token_len = tok_cnt;
        scan_st     = ST_START;
        tok_cnt     = '0;
        return r;
    endfunction

    // idle length: mostly none, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] any_space();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'h09;
            2: return 8'h0a;
            3: return 8'h0b;
            4: return 8'h0c;
            default: return 8'h0d;
        endcase
    endfunction

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        return ($urandom_range(0, 1) != 0) ? (c ^ 8'h20) : c;
    endfunction

    task automatic push_char(input logic [7:0] c);
        pending_chars.push_back(char_item_t'({1'b0, c}));
        chars_queued++;
    endtask

    task automatic push_eoi();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        pending_chars.push_back(char_item_t'({1'b1, junk}));
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endtask

    task automatic push_digits(input int unsigned n);
        logic [7:0] c;
        for (int unsigned i = 0; i < n; i++) begin
            c = 8'("0" + $urandom_range(0, 9));
            push_char(c);
        end
    endtask

    task automatic push_sign();
        logic [7:0] c;
        c = ($urandom_range(0, 1) != 0) ? "+" : "-";
        push_char(c);
    endtask

    // one scan: optional whitespace and sign, a mostly well-formed body, then a terminator
    task automatic gen_scan();
        int unsigned form, n, i;
        logic [7:0]  c;
        string       word;
        form = $urandom_range(0, 99);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (i = 0; i < n; i++) push_char(any_space());
        if (form < 15) begin
            // noise
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                c = 8'($urandom_range(0, 255));
                push_char(c);
            end
        end else begin
            if ($urandom_range(0, 2) == 0) push_sign();
            if (form < 60) begin
                push_digits($urandom_range(0, 6));
                if ($urandom_range(0, 2) == 0) begin
                    push_char(".");
                    push_digits($urandom_range(0, 4));
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_char(mixed_case("e"));
                    if ($urandom_range(0, 1) != 0) push_sign();
                    push_digits($urandom_range(0, 3));
                end
            end else if (form < 80) begin
                word = "nan";
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 3;
                for (i = 0; i < n; i++) push_char(mixed_case(word[i]));
                if (n == 3 && $urandom_range(0, 1) != 0) begin
                    push_char("(");
                    n = $urandom_range(0, 5);
                    for (i = 0; i < n; i++) begin
                        case ($urandom_range(0, 3))
                            0: c = 8'("0" + $urandom_range(0, 9));
                            1: c = 8'("A" + $urandom_range(0, 25));
                            2: c = 8'("a" + $urandom_range(0, 25));
                            default: c = "_";
                        endcase
                        push_char(c);
                    end
                    if ($urandom_range(0, 4) != 0) push_char(")");
                end
            end else begin
                word = "infinity";
                if ($urandom_range(0, 2) == 0) n = $urandom_range(1, 8);
                else n = ($urandom_range(0, 1) != 0) ? 3 : 8;
                for (i = 0; i < n; i++) push_char(mixed_case(word[i]));
            end
        end
        case ($urandom_range(0, 9))
            0: push_eoi();
            1, 2: push_char(any_space());
            default: begin
                c = 8'($urandom_range(0, 255));
                push_char(c);
            end
        endcase
    endtask

    // block idle: everything sent and every result back, plus a short settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LenWidth-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        tok_limit = v;
        @(negedge aclk);
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
        mismatches++;
        $display("%0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
    endtask

    // driver: predicts each accepted item, then offers the next one after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_scan(char_item_t'({s_tuser, s_tdata})));
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    drv_item = pending_chars.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_item.ch;
                    s_tuser  <= drv_item.eoi;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result item with nothing expected, expected none got %h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[7:0] !== want.ch_out)
                        note_mismatch("ch_out", want.ch_out, m_tdata[7:0]);
                    if (m_tdata[9:8] !== want.action)
                        note_mismatch("action", 8'(want.action), 8'(m_tdata[9:8]));
                    if (m_tdata[11:10] !== want.status)
                        note_mismatch("status", 8'(want.status), 8'(m_tdata[11:10]));
                    if (m_tdata[19:12] !== want.token_len)
                        note_mismatch("token_len", want.token_len, m_tdata[19:12]);
                    if (m_tdata[MTdataWidth-1:20] !== '0)
                        note_mismatch("padding", 8'd0, 8'(m_tdata[MTdataWidth-1:20]));
                end
                // long hold-off so the result register fills and s_tready drops
                if (results_seen == HoldOffAtA || results_seen == HoldOffAtB)
                    ready_hold = HoldOffCycles;
            end
            if (ready_hold > 0) begin
                ready_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                ready_hold = pick_gap();
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset limit: full number with fraction and signed exponent, ended by whitespace
        push_text("\t-1.5E+3 ");
        push_eoi();                 // end of input before anything
        push_text("nAn(_Z)");
        push_eoi();                 // end of input inside a token
        push_text(" ");
        push_eoi();                 // end of input after whitespace only
        push_text("E5;");           // exponent with no mantissa
        wait_drained();

        // zero limit: every would-be append ends the scan with an empty token
        write_limit(8'd0);
        push_text("7+");
        push_char(8'hff);
        push_char(8'h00);
        wait_drained();

        // limit of one: second digit is handed back
        write_limit(8'd1);
        push_text("12");
        wait_drained();

        phase_limits = '{255, 2, 120, 0, 6, 1};
        phase_limits[3] = $urandom_range(3, 254);
        for (int p = 0; p < 6; p++) begin
            write_limit(LenWidth'(phase_limits[p]));
            idle_on = (p != 2);
            chars_queued = 0;
            if (p == 0) begin
                // one token runs into the full-scale limit
                for (int i = 0; i < 258; i++) push_char("7");
                push_char(";");
            end
            while (chars_queued < ((p == 0) ? 370 : 110)) gen_scan();
            wait_drained();
        end
        idle_on = 1'b1;
        repeat (4) @(negedge aclk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ntr_pkg.sv
rtl/core/numeric_token_recognizer_unit.sv
sim/tb_numeric_token_recognizer_unit.sv
